/* design/assert_macros.svh */
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define CVC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cvc assertion failed");

// Next-cycle implication, disabled in reset.
`define CVC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cvc assertion failed");

`endif

/* design/cvc_pkg.sv */
package cvc_pkg;

    localparam int DIM_W     = 13;
    localparam int POS_W     = 12;
    localparam int START_W   = 12;
    localparam int DIM_MAX   = (1 << DIM_W) - 1;
    localparam int RW        = 22;
    localparam int SW        = RW + 1;
    localparam int NUMW      = DIM_W + SW;
    localparam int RADW      = 2 * RW;
    localparam int DIV_W     = DIM_W + 1;
    localparam int RECIP_W   = 16;
    localparam int CNT_W     = 5;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_WIDTH_X      = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_HEIGHT_Z     = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_TUNNEL_START = 2'd2;

    // x / 100 as (x * ceil(2^19 / 100)) >> 19, exact for x below 43690
    localparam logic [RECIP_W-1:0] WALL_RECIP  = 16'd5243;
    localparam int                 WALL_SHIFT  = 19;
    // x / 3 as (x * ceil(2^16 / 3)) >> 16, exact for x below 32768
    localparam logic [RECIP_W-1:0] THIRD_RECIP = 16'd21846;
    localparam int                 THIRD_SHIFT = 16;
    localparam logic [DIM_W-1:0]   WALL_MIN    = 13'd10;

    // one digit of the bit-pair square root
    typedef struct packed {
        logic [RW+1:0]   rem;
        logic [RW-1:0]   root;
        logic [RADW-1:0] rad;
    } sq_t;

    // constants derived from the configuration
    typedef struct packed {
        logic [DIM_W-1:0] wall;
        logic [DIM_W-1:0] xwall;
        logic [DIM_W-1:0] fz;
        logic [DIM_W-1:0] st;
        logic [DIM_W-1:0] vc;
        logic [DIM_W-1:0] lc;
        logic [DIM_W-1:0] rc;
        logic [SW-1:0]    base;
        logic [SW-1:0]    roof_diff;
        logic [SW-1:0]    flr_diff;
        logic             roof_ok;
        logic             flr_ok;
        logic [DIM_W-1:0] span_r;
        logic [DIM_W-1:0] span_f;
    } cvc_const_t;

    typedef enum logic [3:0] {
        CFG_IDLE,
        CFG_LOAD,
        CFG_WALL,
        CFG_SETUP,
        CFG_DIVL,
        CFG_LC,
        CFG_DIVR,
        CFG_RC,
        CFG_RAD,
        CFG_SQRT,
        CFG_FIN
    } cfg_state_t;

    function automatic sq_t sqrt_step(input sq_t s);
        sq_t           o;
        logic [RW+1:0] r2;
        logic [RW+1:0] t;
        r2    = {s.rem[RW-1:0], s.rad[RADW-1 -: 2]};
        t     = {s.root, 2'b01};
        o.rad = {s.rad[RADW-3:0], 2'b00};
        if (r2 >= t)
        begin
            o.rem  = r2 - t;
            o.root = {s.root[RW-2:0], 1'b1};
        end
        else
        begin
            o.rem  = r2;
            o.root = {s.root[RW-2:0], 1'b0};
        end
        return o;
    endfunction

    function automatic logic [DIM_W-1:0] absdiff(input logic [DIM_W-1:0] a,
                                                 input logic [DIM_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

endpackage

/* design/cvc_cfg.sv */
module cvc_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            go,
    input  logic [cvc_pkg::DIM_W-1:0]       xs,
    input  logic [cvc_pkg::DIM_W-1:0]       zs,
    input  logic [cvc_pkg::START_W-1:0]     tstart,
    output logic                            busy,
    output cvc_pkg::cvc_const_t             cst
);

    localparam int DW = cvc_pkg::DIM_W;
    localparam int PW = cvc_pkg::DIV_W + cvc_pkg::RECIP_W;
    localparam logic [cvc_pkg::CNT_W-1:0] SQ_LAST  = cvc_pkg::CNT_W'(cvc_pkg::RW - 1);
    localparam logic [1:0] N_ROOTS = 2'd3;

    cvc_pkg::cfg_state_t state_reg, state_next;

    logic [cvc_pkg::DIV_W-1:0]  num_reg, dq_reg;
    logic [cvc_pkg::CNT_W-1:0]  cnt_reg;
    logic [1:0]                 sidx_reg;
    cvc_pkg::sq_t               sq_reg;
    logic [cvc_pkg::RW-1:0]     root_a_reg, root_b_reg;
    logic [DW-1:0] wall_reg, fz_reg, st_reg, vc_reg, inner_reg, xwall_reg, roofx_reg;
    logic [DW-1:0] lc_reg, rc_reg;
    cvc_pkg::cvc_const_t        cst_reg;

    // reciprocal products for the constant divisions
    logic [PW-1:0]              wall_prod, third_prod;
    // setup
    logic [DW-1:0]              wall_c, fz_c, st_c, vc_c, inner_c;
    logic [cvc_pkg::DIV_W-1:0]  two_w;
    // radicand
    logic [DW-1:0]              d1, d2;
    logic [2*DW:0]              sqsum;
    // final
    logic [DW-1:0]              lcw, rcw;
    logic [cvc_pkg::SW-1:0]     base_c, roof_c, flr_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= cvc_pkg::CFG_LOAD;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cvc_pkg::CFG_IDLE:  state_next = cvc_pkg::CFG_IDLE;
            cvc_pkg::CFG_LOAD:  state_next = cvc_pkg::CFG_WALL;
            cvc_pkg::CFG_WALL:  state_next = cvc_pkg::CFG_SETUP;
            cvc_pkg::CFG_SETUP: state_next = cvc_pkg::CFG_DIVL;
            cvc_pkg::CFG_DIVL:  state_next = cvc_pkg::CFG_LC;
            cvc_pkg::CFG_LC:    state_next = cvc_pkg::CFG_DIVR;
            cvc_pkg::CFG_DIVR:  state_next = cvc_pkg::CFG_RC;
            cvc_pkg::CFG_RC:    state_next = cvc_pkg::CFG_RAD;
            cvc_pkg::CFG_RAD:   state_next = cvc_pkg::CFG_SQRT;
            cvc_pkg::CFG_SQRT:
            begin
                if (cnt_reg == SQ_LAST)
                    state_next = (sidx_reg == N_ROOTS) ? cvc_pkg::CFG_FIN
                                                       : cvc_pkg::CFG_RAD;
            end
            cvc_pkg::CFG_FIN:   state_next = cvc_pkg::CFG_IDLE;
            default:            state_next = cvc_pkg::CFG_IDLE;
        endcase
        if (go)
            state_next = cvc_pkg::CFG_LOAD;
        busy = (state_reg != cvc_pkg::CFG_IDLE);
        cst  = cst_reg;
    end

    always_comb
    begin
        wall_prod  = PW'(num_reg) * PW'(cvc_pkg::WALL_RECIP);
        third_prod = PW'(num_reg) * PW'(cvc_pkg::THIRD_RECIP);

        wall_c  = (dq_reg > cvc_pkg::DIV_W'(cvc_pkg::WALL_MIN)) ? dq_reg[DW-1:0]
                                                               : cvc_pkg::WALL_MIN;
        fz_c    = (zs >= wall_c) ? zs - wall_c : '0;
        st_c    = (DW'(tstart) > fz_c) ? fz_c : DW'(tstart);
        vc_c    = st_c + ((fz_c - st_c) >> 1);
        two_w   = {wall_c, 1'b0};
        inner_c = ({1'b0, xs} > two_w) ? DW'({1'b0, xs} - two_w) : '0;

        case (sidx_reg)
            2'd0:
            begin
                d1 = cvc_pkg::absdiff(lc_reg, roofx_reg);
                d2 = vc_reg - st_reg;
            end
            2'd1:
            begin
                d1 = cvc_pkg::absdiff(rc_reg, roofx_reg);
                d2 = vc_reg - st_reg;
            end
            default:
            begin
                d1 = rc_reg - lc_reg;
                d2 = fz_reg - vc_reg;
            end
        endcase
        sqsum = (2*DW+1)'(d1 * d1) + (2*DW+1)'(d2 * d2);

        lcw    = lc_reg - wall_reg;
        rcw    = rc_reg - wall_reg;
        base_c = cvc_pkg::SW'({({1'b0, lcw} + {1'b0, rcw}), 8'h00});
        roof_c = cvc_pkg::SW'(root_a_reg) + cvc_pkg::SW'(root_b_reg);
        flr_c  = cvc_pkg::SW'({(fz_reg - vc_reg), 8'h00}) + cvc_pkg::SW'(sq_reg.root);
    end

    always_ff @(posedge clk)
    begin
        case (state_reg) inside
            cvc_pkg::CFG_LOAD:
            begin
                num_reg  <= {1'b0, xs};
                cnt_reg  <= '0;
                sidx_reg <= '0;
            end
            cvc_pkg::CFG_WALL:
            begin
                dq_reg <= cvc_pkg::DIV_W'(wall_prod >> cvc_pkg::WALL_SHIFT);
            end
            cvc_pkg::CFG_DIVL, cvc_pkg::CFG_DIVR:
            begin
                dq_reg <= cvc_pkg::DIV_W'(third_prod >> cvc_pkg::THIRD_SHIFT);
            end
            cvc_pkg::CFG_SETUP:
            begin
                wall_reg    <= wall_c;
                fz_reg      <= fz_c;
                st_reg      <= st_c;
                vc_reg      <= vc_c;
                inner_reg   <= inner_c;
                xwall_reg   <= (xs >= wall_c) ? xs - wall_c : '0;
                roofx_reg   <= wall_c + (inner_c >> 2);
                num_reg     <= {1'b0, inner_c};
            end
            cvc_pkg::CFG_LC:
            begin
                lc_reg   <= wall_reg + dq_reg[DW-1:0];
                num_reg  <= {inner_reg, 1'b0};
            end
            cvc_pkg::CFG_RC:
            begin
                rc_reg <= wall_reg + dq_reg[DW-1:0];
            end
            cvc_pkg::CFG_RAD:
            begin
                // shift earlier roots down; the last one is read in FIN
                root_a_reg  <= root_b_reg;
                root_b_reg  <= sq_reg.root;
                sq_reg.rem  <= '0;
                sq_reg.root <= '0;
                sq_reg.rad  <= cvc_pkg::RADW'({sqsum, 16'h0000});
                sidx_reg    <= sidx_reg + 1'b1;
                cnt_reg     <= '0;
            end
            cvc_pkg::CFG_SQRT:
            begin
                sq_reg  <= cvc_pkg::sqrt_step(sq_reg);
                cnt_reg <= cnt_reg + 1'b1;
            end
            cvc_pkg::CFG_FIN:
            begin
                cst_reg.wall      <= wall_reg;
                cst_reg.xwall     <= xwall_reg;
                cst_reg.fz        <= fz_reg;
                cst_reg.st        <= st_reg;
                cst_reg.vc        <= vc_reg;
                cst_reg.lc        <= lc_reg;
                cst_reg.rc        <= rc_reg;
                cst_reg.base      <= base_c;
                cst_reg.roof_diff <= roof_c - base_c;
                cst_reg.flr_diff  <= flr_c - base_c;
                cst_reg.roof_ok   <= (roof_c > base_c) && (vc_reg > st_reg);
                cst_reg.flr_ok    <= (flr_c > base_c) && (fz_reg > vc_reg);
                cst_reg.span_r    <= vc_reg - st_reg;
                cst_reg.span_f    <= fz_reg - vc_reg;
            end
            default:
            begin
            end
        endcase
    end

endmodule

/* design/cvc_item.sv */
module cvc_item (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [cvc_pkg::POS_W-1:0]     px,
    input  logic [cvc_pkg::POS_W-1:0]     pz,
    input  cvc_pkg::cvc_const_t           cst,
    output logic                          out_valid,
    output logic                          out_rock
);

    localparam int DW   = cvc_pkg::DIM_W;
    localparam int RW   = cvc_pkg::RW;
    localparam int SW   = cvc_pkg::SW;
    localparam int NUMW = cvc_pkg::NUMW;

    // stage A
    logic          a_valid_reg;
    logic [DW-1:0] a_dx1_reg, a_dx2_reg, a_dz_reg;
    logic          a_below_reg, a_wall_reg, a_upper_reg;
    logic [DW-1:0] px_e, pz_e;

    // stage B is element 0 of the step arrays
    cvc_pkg::sq_t     sq1_reg [0:RW];
    cvc_pkg::sq_t     sq2_reg [0:RW];
    logic [NUMW-1:0]  num_reg [0:SW];
    logic [SW-1:0]    q_reg   [0:SW];
    logic [DW-1:0]    den_reg [0:SW];
    logic             vld_reg   [0:SW];
    logic             below_reg [0:SW];
    logic             hit_reg   [0:SW];
    logic             use_reg   [0:SW];
    logic [SW-1:0]    sum_reg;

    logic             done_reg, rock_reg;
    logic [SW:0]      thr;

    assign px_e = DW'(px);
    assign pz_e = DW'(pz);

    always_comb
    begin
        thr = (SW+1)'(cst.base) + (use_reg[SW] ? (SW+1)'(q_reg[SW]) : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            vld_reg[0]  <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            vld_reg[0]  <= a_valid_reg;
            done_reg    <= vld_reg[SW];
        end
    end

    always_ff @(posedge clk)
    begin
        a_dx1_reg   <= cvc_pkg::absdiff(px_e, cst.lc);
        a_dx2_reg   <= cvc_pkg::absdiff(px_e, cst.rc);
        a_dz_reg    <= cvc_pkg::absdiff(pz_e, cst.vc);
        a_below_reg <= (pz_e < cst.st);
        a_wall_reg  <= (px_e < cst.wall) || (px_e >= cst.xwall) || (pz_e >= cst.fz);
        a_upper_reg <= (pz_e < cst.vc);

        sq1_reg[0].rem  <= '0;
        sq1_reg[0].root <= '0;
        sq1_reg[0].rad  <= cvc_pkg::RADW'({((2*DW+1)'(a_dx1_reg * a_dx1_reg)
                                           + (2*DW+1)'(a_dz_reg * a_dz_reg)), 16'h0000});
        sq2_reg[0].rem  <= '0;
        sq2_reg[0].root <= '0;
        sq2_reg[0].rad  <= cvc_pkg::RADW'({((2*DW+1)'(a_dx2_reg * a_dx2_reg)
                                           + (2*DW+1)'(a_dz_reg * a_dz_reg)), 16'h0000});
        // |pz - vc| is also the interpolation offset on either side
        num_reg[0]   <= NUMW'(a_dz_reg * (a_upper_reg ? cst.roof_diff : cst.flr_diff));
        den_reg[0]   <= a_upper_reg ? cst.span_r : cst.span_f;
        use_reg[0]   <= a_upper_reg ? cst.roof_ok : cst.flr_ok;
        q_reg[0]     <= '0;
        below_reg[0] <= a_below_reg;
        hit_reg[0]   <= a_wall_reg;

        sum_reg <= SW'(sq1_reg[RW].root) + SW'(sq2_reg[RW].root);

        rock_reg <= !below_reg[SW] && (hit_reg[SW] || ((SW+1)'(sum_reg) > thr));
    end

    genvar k;
    generate
        for (k = 0; k < RW; k++)
        begin : g_sqrt
            always_ff @(posedge clk)
            begin
                sq1_reg[k+1] <= cvc_pkg::sqrt_step(sq1_reg[k]);
                sq2_reg[k+1] <= cvc_pkg::sqrt_step(sq2_reg[k]);
            end
        end

        for (k = 0; k < SW; k++)
        begin : g_div
            localparam int B = SW - 1 - k;
            logic            ge;
            logic [NUMW-1:0] rem_n;

            always_comb
            begin
                ge    = ((num_reg[k] >> B) >= NUMW'(den_reg[k]));
                rem_n = ge ? num_reg[k] - (NUMW'(den_reg[k]) << B) : num_reg[k];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[k+1] <= 1'b0;
                else
                    vld_reg[k+1] <= vld_reg[k];
            end

            always_ff @(posedge clk)
            begin
                num_reg[k+1]   <= rem_n;
                q_reg[k+1]     <= {q_reg[k][SW-2:0], ge};
                den_reg[k+1]   <= den_reg[k];
                use_reg[k+1]   <= use_reg[k];
                below_reg[k+1] <= below_reg[k];
                hit_reg[k+1]   <= hit_reg[k];
            end
        end
    endgenerate

    assign out_valid = done_reg;
    assign out_rock  = rock_reg;

endmodule

/* design/cave_tunnel_voxel_classifier.sv */
// Result: a coordinate accepted at one edge gives its result with done/make_rock
//   high for one cycle; the path runs through the 22-digit square root and
//   23-digit threshold divider stages, one digit per stage.
// Throughput: one voxel per cycle while busy is low; the results cannot be held off.
// Reset and config: after reset and after every config write, busy stays high
//   while the derived constants are recomputed.
`include "assert_macros.svh"

module cave_tunnel_voxel_classifier #(
    parameter int unsigned MAX_DIM = 4096
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // voxel command channel
    input  logic                               start,
    output logic                               busy,
    input  logic [cvc_pkg::POS_W-1:0]          pos_x,
    input  logic [cvc_pkg::POS_W-1:0]          pos_z,
    // result strobe
    output logic                               done,
    output logic                               make_rock,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [cvc_pkg::REG_IDX_W-1:0]      cfg_addr,
    input  logic [cvc_pkg::DIM_W-1:0]          cfg_wdata
);

    // Extents above MAX_DIM are clamped before anything else sees them.
    localparam int unsigned CLAMP = (MAX_DIM < cvc_pkg::DIM_MAX) ? MAX_DIM
                                                                 : cvc_pkg::DIM_MAX;
    localparam int LAT = cvc_pkg::SW + 3;

    logic [cvc_pkg::DIM_W-1:0]   width_x_reg, height_z_reg;
    logic [cvc_pkg::START_W-1:0] tunnel_start_reg;
    logic [cvc_pkg::DIM_W-1:0]   xs, zs;
    logic                        accept;
    cvc_pkg::cvc_const_t         cst;

    // Config registers: plain writes, no read-back. Index three is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_x_reg      <= 13'd256;
            height_z_reg     <= 13'd256;
            tunnel_start_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                cvc_pkg::REG_WIDTH_X:      width_x_reg      <= cfg_wdata;
                cvc_pkg::REG_HEIGHT_Z:     height_z_reg     <= cfg_wdata;
                cvc_pkg::REG_TUNNEL_START: tunnel_start_reg <= cfg_wdata[cvc_pkg::START_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign xs = (32'(width_x_reg) > CLAMP) ? cvc_pkg::DIM_W'(CLAMP) : width_x_reg;
    assign zs = (32'(height_z_reg) > CLAMP) ? cvc_pkg::DIM_W'(CLAMP) : height_z_reg;

    // Sequencer for the per-configuration constants: wall, centers, focus
    // points, and the base/roof/floor focus sums (three serial square roots).
    cvc_cfg u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (cfg_we),
        .xs     (xs),
        .zs     (zs),
        .tstart (tunnel_start_reg),
        .busy   (busy),
        .cst    (cst)
    );

    // A transaction is taken whenever start is high and busy is low.
    assign accept = start && !busy;

    // Per-voxel pipeline: distances, two pipelined square roots, the
    // threshold interpolation divider, then the final compare.
    cvc_item u_item (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .px        (pos_x),
        .pz        (pos_z),
        .cst       (cst),
        .out_valid (done),
        .out_rock  (make_rock)
    );

    // Every accepted transaction yields exactly one strobe, a fixed time later.
    `CVC_ASSERT_IMP(a_result_follows, $past(accept, LAT), done)
    `CVC_ASSERT_IMP(a_result_has_cause, done, $past(accept, LAT))
    // Outside reset, the constant sequencer only restarts on a config write.
    `CVC_ASSERT_IMP(a_busy_from_write, $rose(busy), $past(cfg_we))

endmodule
